// File: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU write-back cache tag
// block: address split, per-way entry layout, controller states and commands.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int ADDR_BITS   = 32;
   localparam int NUM_SETS    = 1024;
   localparam int NUM_WAYS    = 4;
   localparam int LINE_BYTES  = 32;

   localparam int OFFSET_BITS = $clog2(LINE_BYTES);
   localparam int SET_BITS    = $clog2(NUM_SETS);
   localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
   localparam int WAY_BITS    = $clog2(NUM_WAYS);
   localparam int AGE_BITS    = $clog2(NUM_WAYS);

   localparam int LAT_BITS    = 10;
   localparam int COST_BITS   = 11;

   localparam logic [LAT_BITS-1:0] LAT_RESET = LAT_BITS'(50);
   localparam logic [AGE_BITS-1:0] AGE_MAX   = AGE_BITS'(NUM_WAYS - 1);
   localparam logic [SET_BITS-1:0] SET_LAST  = SET_BITS'(NUM_SETS - 1);

   // Access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [AGE_BITS-1:0] age;
      logic [TAG_BITS-1:0] tag;
   } way_entry_type;

   typedef way_entry_type [NUM_WAYS-1:0] set_row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic                capture;    // latch request, start set read
      logic                clear_we;   // write a zero row during the clearing pass
      logic [SET_BITS-1:0] clear_set;
      logic                commit;     // write updated row, load result register
   } ctrl_cmd_type;

endpackage

// File: rtl/set_assoc_cache_lru_writeback.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_writeback
// Tag and replacement-policy block of a 4-way write-back, write-allocate
// data cache with true-LRU ages, dirty victim reporting and access cost.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_cmd, req_address
//   rsp      out        rsp_valid/rsp_ready  hit, way, filled_empty, write_back,
//                                            write_back_address, access_cost
//   csr      in         csr_we (no wait)     csr_wdata (memory_latency)
//
// Each item first reads its set row from the set memory into a register,
// then evaluates and writes the updated row back, so a new item is not
// taken before the previous one has written its row back.
// After reset a clearing pass writes zero into all 1024 set rows, one per
// cycle; req_ready stays low until the pass is done. Configuration writes are
// taken at any time.
// A finished item sits in the result register while the next item is taken
// and read; that item waits in its lookup cycle while the result is stalled.
//
module set_assoc_cache_lru_writeback (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [sacl_pkg::WAY_BITS-1:0]     rsp_way,
   output logic                              rsp_filled_empty,
   output logic                              rsp_write_back,
   output logic [sacl_pkg::ADDR_BITS-1:0]    rsp_write_back_address,
   output logic [sacl_pkg::COST_BITS-1:0]    rsp_access_cost,
   input  logic                              csr_we,
   input  logic [sacl_pkg::LAT_BITS-1:0]     csr_wdata
);

   // Commands from the controller to the datapath.
   sacl_pkg::ctrl_cmd_type cmd;

   // The controller sequences the clearing pass and each lookup.
   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the set memory and evaluates hit, fill and victim.
   sacl_dpath u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_cmd                (req_cmd),
      .req_address            (req_address),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .rsp_hit                (rsp_hit),
      .rsp_way                (rsp_way),
      .rsp_filled_empty       (rsp_filled_empty),
      .rsp_write_back         (rsp_write_back),
      .rsp_write_back_address (rsp_write_back_address),
      .rsp_access_cost        (rsp_access_cost)
   );

`ifndef SYNTHESIS
   // A result may only be loaded when the result register is free or draining.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending item");

   // An accepted item is never followed by another in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken during lookup");

   // A result appears only after a commit.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result valid without commit");

   // A hit never evicts a line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (!rsp_write_back && !rsp_filled_empty))
      else $error("hit reported with eviction or fill");
`endif

endmodule

// File: rtl/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// Controller: clearing pass after reset, request handshake, lookup sequencing
// and the result valid flag.
// ----------------------------------------------------------------------------
module sacl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sacl_pkg::ctrl_cmd_type cmd
);

   sacl_pkg::state_type                state_ff, state_in;
   logic [sacl_pkg::SET_BITS-1:0]      clear_cnt_ff, clear_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.clear_we  = 1'b0;
      cmd.clear_set = clear_cnt_ff;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            clear_cnt_in = clear_cnt_ff + sacl_pkg::SET_BITS'(1);
            if (clear_cnt_ff == sacl_pkg::SET_LAST) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         sacl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sacl_pkg::ST_LOOKUP;
            end
         end
         sacl_pkg::ST_LOOKUP: begin
            // The update waits until the result register can take the item.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = sacl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/sacl_dpath.sv
// ----------------------------------------------------------------------------
// sacl_dpath
// Datapath: set memory, request registers, hit / fill / victim selection,
// LRU age update, write-back address and cost, result registers.
// ----------------------------------------------------------------------------
module sacl_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  sacl_pkg::ctrl_cmd_type            cmd,
   input  logic                              req_cmd,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    req_address,
   input  logic                              csr_we,
   input  logic [sacl_pkg::LAT_BITS-1:0]     csr_wdata,
   output logic                              rsp_hit,
   output logic [sacl_pkg::WAY_BITS-1:0]     rsp_way,
   output logic                              rsp_filled_empty,
   output logic                              rsp_write_back,
   output logic [sacl_pkg::ADDR_BITS-1:0]    rsp_write_back_address,
   output logic [sacl_pkg::COST_BITS-1:0]    rsp_access_cost
);

   sacl_pkg::set_row_type               set_mem [sacl_pkg::NUM_SETS];
   sacl_pkg::set_row_type               row_ff;

   logic [sacl_pkg::LAT_BITS-1:0]       latency_ff;
   logic                                cmd_ff;
   logic [sacl_pkg::TAG_BITS-1:0]       tag_ff;
   logic [sacl_pkg::SET_BITS-1:0]       set_ff;

   logic                                mem_we;
   logic [sacl_pkg::SET_BITS-1:0]       mem_waddr;
   sacl_pkg::set_row_type               mem_wdata;

   logic                                hit_c;
   logic                                empty_found_c;
   logic                                wb_c;
   logic [sacl_pkg::WAY_BITS-1:0]       hit_way_c, empty_way_c, victim_way_c, sel_way_c;
   logic [sacl_pkg::AGE_BITS-1:0]       victim_age_c, sel_age_c;
   sacl_pkg::set_row_type               new_row_c;
   logic [sacl_pkg::ADDR_BITS-1:0]      wb_addr_c;
   logic [sacl_pkg::COST_BITS-1:0]      cost_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff <= sacl_pkg::LAT_RESET;
      end else if (csr_we) begin
         latency_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         tag_ff <= req_address[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_BITS];
         set_ff <= req_address[sacl_pkg::OFFSET_BITS +: sacl_pkg::SET_BITS];
      end
   end

   // Set memory: one row per set, registered read.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= set_mem[req_address[sacl_pkg::OFFSET_BITS +: sacl_pkg::SET_BITS]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[mem_waddr] <= mem_wdata;
      end
   end

   assign mem_we    = cmd.clear_we | cmd.commit;
   assign mem_waddr = cmd.clear_we ? cmd.clear_set : set_ff;
   assign mem_wdata = cmd.clear_we ? '0 : new_row_c;

   always_comb begin
      hit_c         = 1'b0;
      hit_way_c     = '0;
      empty_found_c = 1'b0;
      empty_way_c   = '0;
      // Descending scans leave the lowest matching way selected.
      for (int w = sacl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].valid && row_ff[w].tag == tag_ff) begin
            hit_c     = 1'b1;
            hit_way_c = sacl_pkg::WAY_BITS'(w);
         end
         if (!row_ff[w].valid) begin
            empty_found_c = 1'b1;
            empty_way_c   = sacl_pkg::WAY_BITS'(w);
         end
      end

      // Oldest way, lowest index on a tie.
      victim_way_c = '0;
      victim_age_c = row_ff[0].age;
      for (int w = 1; w < sacl_pkg::NUM_WAYS; w++) begin
         if (row_ff[w].age > victim_age_c) begin
            victim_age_c = row_ff[w].age;
            victim_way_c = sacl_pkg::WAY_BITS'(w);
         end
      end

      if (hit_c) begin
         sel_way_c = hit_way_c;
      end else if (empty_found_c) begin
         sel_way_c = empty_way_c;
      end else begin
         sel_way_c = victim_way_c;
      end
      sel_age_c = row_ff[sel_way_c].age;

      new_row_c = row_ff;
      for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
         if (hit_c || !empty_found_c) begin
            if (row_ff[w].age < sel_age_c) begin
               new_row_c[w].age = row_ff[w].age + sacl_pkg::AGE_BITS'(1);
            end
         end else if (row_ff[w].valid && row_ff[w].age != sacl_pkg::AGE_MAX) begin
            new_row_c[w].age = row_ff[w].age + sacl_pkg::AGE_BITS'(1);
         end
      end
      new_row_c[sel_way_c].age = '0;
      if (hit_c) begin
         new_row_c[sel_way_c].dirty = row_ff[sel_way_c].dirty | (cmd_ff == sacl_pkg::CMD_WRITE);
      end else begin
         new_row_c[sel_way_c].valid = 1'b1;
         new_row_c[sel_way_c].tag   = tag_ff;
         new_row_c[sel_way_c].dirty = (cmd_ff == sacl_pkg::CMD_WRITE);
      end

      wb_c      = !hit_c && !empty_found_c && row_ff[victim_way_c].dirty;
      wb_addr_c = wb_c ? {row_ff[victim_way_c].tag, set_ff, {sacl_pkg::OFFSET_BITS{1'b0}}}
                       : '0;
      cost_c    = sacl_pkg::COST_BITS'(1)
                + (hit_c ? '0 : sacl_pkg::COST_BITS'(latency_ff))
                + (wb_c ? sacl_pkg::COST_BITS'(latency_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit                <= hit_c;
         rsp_way                <= sel_way_c;
         rsp_filled_empty       <= !hit_c && empty_found_c;
         rsp_write_back         <= wb_c;
         rsp_write_back_address <= wb_addr_c;
         rsp_access_cost        <= cost_c;
      end
   end

endmodule

// File: tb/sacl_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_lookup_checker
// Watches the request, response and latency ports of the cache tag block.
// It keeps its own copy of tags, valid, dirty and age bits. It predicts each
// lookup result and compares it with the item that the block returns.
// ----------------------------------------------------------------------------
module sacl_lookup_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    req_address,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_hit,
   input  logic [sacl_pkg::WAY_BITS-1:0]     rsp_way,
   input  logic                              rsp_filled_empty,
   input  logic                              rsp_write_back,
   input  logic [sacl_pkg::ADDR_BITS-1:0]    rsp_write_back_address,
   input  logic [sacl_pkg::COST_BITS-1:0]    rsp_access_cost,
   input  logic                              csr_we,
   input  logic [sacl_pkg::LAT_BITS-1:0]     csr_wdata,
   output int                                failures,
   output int                                pending
);
   import sacl_pkg::*;

   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  way;
      logic                 filled_empty;
      logic                 write_back;
      logic [ADDR_BITS-1:0] write_back_address;
      logic [COST_BITS-1:0] access_cost;
   } lookup_result_type;

   logic [TAG_BITS-1:0] tag_mem    [NUM_SETS][NUM_WAYS];
   logic                line_valid [NUM_SETS][NUM_WAYS];
   logic                line_dirty [NUM_SETS][NUM_WAYS];
   logic [AGE_BITS-1:0] line_age   [NUM_SETS][NUM_WAYS];
   logic [LAT_BITS-1:0] latency;
   lookup_result_type   expected_lookups [$];

   // Makes one way the youngest; only ways younger than it grow older.
   function automatic void promote_way(input int set_idx, input int used);
      logic [AGE_BITS-1:0] old_age;
      old_age = line_age[set_idx][used];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (line_age[set_idx][w] < old_age)
            line_age[set_idx][w]++;
      end
      line_age[set_idx][used] = '0;
   endfunction

   function automatic lookup_result_type predict_access(input logic cmd,
                                                        input logic [ADDR_BITS-1:0] addr);
      lookup_result_type   res;
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_BITS-1:0] tag;
      logic                found;
      int                  victim;
      set_idx = addr[OFFSET_BITS +: SET_BITS];
      tag     = addr[ADDR_BITS-1 -: TAG_BITS];
      res     = '0;
      res.access_cost = COST_BITS'(1);
      found   = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
            found   = 1'b1;
            res.way = WAY_BITS'(w);
         end
      end
      if (found) begin
         res.hit = 1'b1;
         if (cmd == CMD_WRITE)
            line_dirty[set_idx][res.way] = 1'b1;
         promote_way(int'(set_idx), int'(res.way));
      end else begin
         victim = -1;
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (victim < 0 && !line_valid[set_idx][w])
               victim = w;
         end
         if (victim >= 0) begin
            // An empty way takes the line; the valid ways all age, saturating.
            res.filled_empty = 1'b1;
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (line_valid[set_idx][w] && line_age[set_idx][w] < AGE_MAX)
                  line_age[set_idx][w]++;
            end
            line_age[set_idx][victim]   = '0;
            line_valid[set_idx][victim] = 1'b1;
         end else begin
            // Oldest way goes, the lowest one when ages tie.
            victim = 0;
            for (int w = 1; w < NUM_WAYS; w++) begin
               if (line_age[set_idx][w] > line_age[set_idx][victim])
                  victim = w;
            end
            if (line_dirty[set_idx][victim]) begin
               res.write_back         = 1'b1;
               res.write_back_address = {tag_mem[set_idx][victim], set_idx,
                                         OFFSET_BITS'(0)};
               res.access_cost        = res.access_cost + COST_BITS'(latency);
            end
            promote_way(int'(set_idx), victim);
         end
         res.way         = WAY_BITS'(victim);
         res.access_cost = res.access_cost + COST_BITS'(latency);
         tag_mem[set_idx][victim]    = tag;
         line_dirty[set_idx][victim] = cmd;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         failures = 0;
         latency  = LAT_RESET;
         expected_lookups.delete();
         for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               tag_mem[s][w]    = '0;
               line_valid[s][w] = 1'b0;
               line_dirty[s][w] = 1'b0;
               line_age[s][w]   = '0;
            end
         end
      end else begin
         if (csr_we)
            latency = csr_wdata;
         // Results are taken before new requests so that a result accepted at
         // the same edge can only match an older item.
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               failures++;
               $display("%0t: result item with no lookup outstanding", $time);
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("way", 32'(want.way), 32'(rsp_way));
               check_field("filled_empty", 32'(want.filled_empty),
                           32'(rsp_filled_empty));
               check_field("write_back", 32'(want.write_back), 32'(rsp_write_back));
               check_field("write_back_address", want.write_back_address,
                           rsp_write_back_address);
               check_field("access_cost", 32'(want.access_cost),
                           32'(rsp_access_cost));
            end
         end
         if (req_valid && req_ready)
            expected_lookups.push_back(predict_access(req_cmd, req_address));
      end
      pending = expected_lookups.size();
   end

endmodule

// File: tb/set_assoc_cache_lru_writeback_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_writeback_tb
// Drives read and write accesses into the cache tag block and gives the
// verdict. A directed sequence walks empty fills, hits, clean and dirty
// evictions and the address extremes. Random phases at several memory
// latencies then follow, and the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_writeback_tb;
   import sacl_pkg::*;

   localparam int RANDOM_PER_PHASE = 360;
   localparam int NUM_PHASES       = 5;
   localparam int IDLE_PCT         = 11;
   // The limit stays far above the length of the clearing pass and of all
   // items together, even with stalls on both sides.
   localparam int CYCLE_LIMIT      = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_cmd;
   logic [ADDR_BITS-1:0] req_address;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [WAY_BITS-1:0]  rsp_way;
   logic                 rsp_filled_empty;
   logic                 rsp_write_back;
   logic [ADDR_BITS-1:0] rsp_write_back_address;
   logic [COST_BITS-1:0] rsp_access_cost;
   logic                 csr_we;
   logic [LAT_BITS-1:0]  csr_wdata;

   int                   failures;
   int                   pending;
   int                   cycles = 0;

   // While calm is high neither side idles.
   logic                 calm = 1'b0;

   // Small pools of sets and tags per phase, so that sets fill up and evict often.
   logic [SET_BITS-1:0]  hot_sets [4];
   logic [TAG_BITS-1:0]  hot_tags [6];
   logic [ADDR_BITS-1:0] last_address = '0;

   set_assoc_cache_lru_writeback dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_cmd                (req_cmd),
      .req_address            (req_address),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_hit                (rsp_hit),
      .rsp_way                (rsp_way),
      .rsp_filled_empty       (rsp_filled_empty),
      .rsp_write_back         (rsp_write_back),
      .rsp_write_back_address (rsp_write_back_address),
      .rsp_access_cost        (rsp_access_cost),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata)
   );

   sacl_lookup_checker checker_inst (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_cmd                (req_cmd),
      .req_address            (req_address),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_hit                (rsp_hit),
      .rsp_way                (rsp_way),
      .rsp_filled_empty       (rsp_filled_empty),
      .rsp_write_back         (rsp_write_back),
      .rsp_write_back_address (rsp_write_back_address),
      .rsp_access_cost        (rsp_access_cost),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .failures               (failures),
      .pending                (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is cut off if the block stops moving.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The result side stalls in about one cycle of nine, except while calm.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic logic [ADDR_BITS-1:0] make_addr(input logic [TAG_BITS-1:0] tag,
                                                      input logic [SET_BITS-1:0] set_idx,
                                                      input logic [OFFSET_BITS-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   // Called at a falling edge and returns at the falling edge after the item
   // has been accepted. Valid stays high between items unless a gap is drawn.
   task automatic send_access(input logic cmd, input logic [ADDR_BITS-1:0] addr);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < IDLE_PCT)
         gap = $urandom_range(1, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_address  <= addr;
      last_address  = addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Lowers valid and waits until every outstanding lookup has returned. Each
   // item yields exactly one result, so the block is idle at that point.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int                   pick;
      logic [ADDR_BITS-1:0] addr;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_READ;
      req_address = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block starts with its clearing pass; send_access simply waits on
      // ready through that pass.

      // Address extremes: lowest and highest address, then hits on both lines
      // with the offset at its other extreme.
      send_access(CMD_READ,  32'h0000_0000);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_READ,  32'hFFFF_FFE0);
      send_access(CMD_WRITE, 32'h0000_001F);

      // Fill one set through all four empty ways, then hit and miss on it so
      // that both a dirty eviction and a clean eviction occur. The write
      // miss leaves a dirty line that is evicted later on.
      send_access(CMD_READ,  make_addr(17'h00001, 10'd5, 5'd0));
      send_access(CMD_WRITE, make_addr(17'h00002, 10'd5, 5'd3));
      send_access(CMD_READ,  make_addr(17'h1FFFF, 10'd5, 5'd31));
      send_access(CMD_WRITE, make_addr(17'h15555, 10'd5, 5'd8));
      send_access(CMD_READ,  make_addr(17'h00001, 10'd5, 5'd1));
      send_access(CMD_READ,  make_addr(17'h0AAAA, 10'd5, 5'd2));
      send_access(CMD_WRITE, make_addr(17'h00007, 10'd5, 5'd4));
      send_access(CMD_READ,  make_addr(17'h15555, 10'd5, 5'd5));
      send_access(CMD_READ,  make_addr(17'h00010, 10'd5, 5'd6));
      send_access(CMD_READ,  make_addr(17'h00011, 10'd5, 5'd7));
      send_access(CMD_READ,  make_addr(17'h00012, 10'd5, 5'd9));
      send_access(CMD_READ,  make_addr(17'h00013, 10'd5, 5'd10));

      // Fill the last set behind the dirty all-ones line so that its eviction
      // reports a write-back address with every tag and set bit high.
      send_access(CMD_WRITE, make_addr(17'h00000, SET_LAST, 5'd0));
      send_access(CMD_WRITE, make_addr(17'h00001, SET_LAST, 5'd0));
      send_access(CMD_WRITE, make_addr(17'h00002, SET_LAST, 5'd0));
      send_access(CMD_WRITE, make_addr(17'h00003, SET_LAST, 5'd0));
      send_access(CMD_READ,  32'h0000_0000);
      drain();

      // Random phases, each at its own memory latency: the minimum, the maximum, a
      // random value, the smallest nonzero value, and another random value.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         csr_we    <= 1'b1;
         csr_wdata <= (phase == 0) ? LAT_BITS'(0) :
                      (phase == 1) ? {LAT_BITS{1'b1}} :
                      (phase == 3) ? LAT_BITS'(1) : LAT_BITS'($urandom);
         @(negedge clock);
         csr_we <= 1'b0;

         for (int i = 0; i < 4; i++)
            hot_sets[i] = SET_BITS'($urandom);
         for (int i = 0; i < 6; i++)
            hot_tags[i] = TAG_BITS'($urandom);

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Part of the middle phase runs with no idling on either side.
            calm <= (phase == 2) && (n < 250);
            pick  = $urandom_range(99);
            if (pick < 70)
               addr = make_addr(hot_tags[$urandom_range(5)], hot_sets[$urandom_range(3)],
                                OFFSET_BITS'($urandom));
            else if (pick < 80)
               // Same line again right behind the previous access.
               addr = {last_address[ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'($urandom)};
            else
               addr = $urandom;
            send_access(($urandom_range(1) == 1) ? CMD_WRITE : CMD_READ, addr);
         end
         calm <= 1'b0;
         drain();
      end

      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dpath.sv
rtl/set_assoc_cache_lru_writeback.sv
tb/sacl_lookup_checker.sv
tb/set_assoc_cache_lru_writeback_tb.sv
